@@ hw/rtl/cstl_pkg.sv @@
// Shared types, constants and helpers for the token lexer.
// Used by every module of the lexer; depends on nothing.
package cstl_pkg;

   localparam int POS_BITS = 32;
   localparam int LEN_BITS = 16;
   localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};
   localparam int QUEUE_DEPTH = 4;
   // Token slots in the queue; a power of two so the pointers wrap on their own
   localparam int QUEUE_SLOTS = QUEUE_DEPTH * 2;
   localparam int QPTR_BITS = $clog2(QUEUE_SLOTS);
   localparam int FILL_BITS = QPTR_BITS + 1;

   typedef enum logic [3:0] {
      MODE_IDLE, MODE_WORD, MODE_NUMBER, MODE_SLASH, MODE_CMP, MODE_LINE,
      MODE_BLOCK, MODE_BLOCK_STAR, MODE_STRING, MODE_STRING_ESC
   } mode_type;

   typedef enum logic [2:0] {
      KIND_END = 3'd0, KIND_KEYWORD = 3'd1, KIND_IDENT = 3'd2, KIND_NUMBER = 3'd3,
      KIND_OPERATOR = 3'd4, KIND_DELIM = 3'd5, KIND_UNKNOWN = 3'd6
   } kind_type;

   typedef struct packed {
      logic [2:0]          kind;
      logic [POS_BITS-1:0] start;
      logic [LEN_BITS-1:0] length;
      logic [3:0]          keyword;
      logic [7:0]          sym1;
      logic [7:0]          sym2;
      logic                last;
   } token_type;

   // Up to three tokens that one byte produces, in order
   typedef struct packed {
      logic [1:0] count;
      token_type  t0;
      token_type  t1;
      token_type  t2;
   } burst_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
   endfunction

   // Match the packed word prefix against the ten keywords
   function automatic logic [4:0] keyword_lookup(input logic [47:0] w,
                                                 input logic [LEN_BITS-1:0] n);
      logic [4:0] r;
      r = 5'd0;
      if      (n == 3 && w == 48'h696e74)        r = {1'b1, 4'd0};
      else if (n == 5 && w == 48'h666c6f6174)    r = {1'b1, 4'd1};
      else if (n == 4 && w == 48'h63686172)      r = {1'b1, 4'd2};
      else if (n == 6 && w == 48'h646f75626c65)  r = {1'b1, 4'd3};
      else if (n == 6 && w == 48'h72657475726e)  r = {1'b1, 4'd4};
      else if (n == 2 && w == 48'h6966)          r = {1'b1, 4'd5};
      else if (n == 4 && w == 48'h656c7365)      r = {1'b1, 4'd6};
      else if (n == 5 && w == 48'h7768696c65)    r = {1'b1, 4'd7};
      else if (n == 3 && w == 48'h666f72)        r = {1'b1, 4'd8};
      else if (n == 4 && w == 48'h766f6964)      r = {1'b1, 4'd9};
      return r;
   endfunction

endpackage

@@ hw/rtl/cstl_front.sv @@
// Front end: takes one byte per request, runs the scan mode machine and
// produces the burst of tokens it causes. Depends on cstl_pkg.
module cstl_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic [7:0]           text_byte,
   input  logic                 end_of_text,
   output cstl_pkg::burst_type  burst
);

   cstl_pkg::mode_type                mode_ff, mode_in;
   logic [cstl_pkg::POS_BITS-1:0]     pos_ff, pos_in, begin_ff, begin_in;
   logic [cstl_pkg::LEN_BITS-1:0]     count_ff, count_in;
   logic [47:0]                       prefix_ff, prefix_in;
   logic [7:0]                        held_ff, held_in;

   // Hold state between bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= cstl_pkg::MODE_IDLE;
         pos_ff    <= '0;
         begin_ff  <= '0;
         count_ff  <= '0;
         prefix_ff <= '0;
         held_ff   <= '0;
      end else if (take) begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         begin_ff  <= begin_in;
         count_ff  <= count_in;
         prefix_ff <= prefix_in;
         held_ff   <= held_in;
      end
   end

   // Step the mode machine and collect tokens
   always_comb begin
      cstl_pkg::token_type tk;
      cstl_pkg::token_type list [3];
      logic [1:0] n;
      logic [4:0] kw;
      logic       restart;
      logic       finish;
      logic [cstl_pkg::POS_BITS-1:0] endpos;
      logic [7:0] c;
      c = text_byte;
      n = 2'd0;
      restart = 1'b0;
      finish = 1'b0;
      tk = '0;
      list[0] = '0;
      list[1] = '0;
      list[2] = '0;
      mode_in = mode_ff;
      begin_in = begin_ff;
      count_in = count_ff;
      prefix_in = prefix_ff;
      held_in = held_ff;
      pos_in = pos_ff + 1'b1;
      endpos = pos_in;
      kw = cstl_pkg::keyword_lookup(prefix_ff, count_ff);

      if (c == 8'd0) begin
         finish = 1'b1;
         endpos = pos_ff;
      end else begin
         unique case (mode_ff)
            cstl_pkg::MODE_WORD: begin
               if (cstl_pkg::is_alpha(c) || cstl_pkg::is_digit(c) || c == 8'h5f) begin
                  if (count_ff < 6) prefix_in = {prefix_ff[39:0], c};
                  if (count_ff != cstl_pkg::LEN_MAX) count_in = count_ff + 1'b1;
               end else begin
                  tk = '0;
                  tk.kind = kw[4] ? cstl_pkg::KIND_KEYWORD : cstl_pkg::KIND_IDENT;
                  tk.keyword = kw[4] ? kw[3:0] : 4'd0;
                  tk.start = begin_ff;
                  tk.length = count_ff;
                  list[n] = tk; n = n + 1'b1;
                  restart = 1'b1;
               end
            end
            cstl_pkg::MODE_NUMBER: begin
               if (cstl_pkg::is_digit(c)) begin
                  if (count_ff != cstl_pkg::LEN_MAX) count_in = count_ff + 1'b1;
               end else begin
                  tk = '0;
                  tk.kind = cstl_pkg::KIND_NUMBER;
                  tk.start = begin_ff;
                  tk.length = count_ff;
                  list[n] = tk; n = n + 1'b1;
                  restart = 1'b1;
               end
            end
            cstl_pkg::MODE_SLASH: begin
               if (c == 8'h2f) mode_in = cstl_pkg::MODE_LINE;
               else if (c == 8'h2a) mode_in = cstl_pkg::MODE_BLOCK;
               else begin
                  tk = '0;
                  tk.kind = cstl_pkg::KIND_OPERATOR;
                  tk.start = begin_ff;
                  tk.length = cstl_pkg::LEN_BITS'(1);
                  tk.sym1 = 8'h2f;
                  list[n] = tk; n = n + 1'b1;
                  restart = 1'b1;
               end
            end
            cstl_pkg::MODE_CMP: begin
               tk = '0;
               tk.kind = cstl_pkg::KIND_OPERATOR;
               tk.start = begin_ff;
               tk.sym1 = held_ff;
               if (c == 8'h3d) begin
                  tk.length = cstl_pkg::LEN_BITS'(2);
                  tk.sym2 = 8'h3d;
                  mode_in = cstl_pkg::MODE_IDLE;
               end else begin
                  tk.length = cstl_pkg::LEN_BITS'(1);
                  restart = 1'b1;
               end
               list[n] = tk; n = n + 1'b1;
            end
            cstl_pkg::MODE_LINE: begin
               if (c == 8'h0a) mode_in = cstl_pkg::MODE_IDLE;
            end
            cstl_pkg::MODE_BLOCK: begin
               if (c == 8'h2a) mode_in = cstl_pkg::MODE_BLOCK_STAR;
            end
            cstl_pkg::MODE_BLOCK_STAR: begin
               if (c == 8'h2f) mode_in = cstl_pkg::MODE_IDLE;
               else if (c != 8'h2a) mode_in = cstl_pkg::MODE_BLOCK;
            end
            cstl_pkg::MODE_STRING: begin
               if (c == 8'h22) mode_in = cstl_pkg::MODE_IDLE;
               else if (c == 8'h5c) mode_in = cstl_pkg::MODE_STRING_ESC;
            end
            cstl_pkg::MODE_STRING_ESC: mode_in = cstl_pkg::MODE_STRING;
            default: restart = 1'b1;
         endcase

         // Start a new token from idle
         if (restart) begin
            mode_in = cstl_pkg::MODE_IDLE;
            tk = '0;
            tk.start = pos_ff;
            tk.length = cstl_pkg::LEN_BITS'(1);
            tk.sym1 = c;
            if (cstl_pkg::is_space(c)) begin
            end else if (c == 8'h2f) begin
               mode_in = cstl_pkg::MODE_SLASH; begin_in = pos_ff;
            end else if (c == 8'h22) begin
               mode_in = cstl_pkg::MODE_STRING;
            end else if (c == 8'h23) begin
               mode_in = cstl_pkg::MODE_LINE;
            end else if (cstl_pkg::is_alpha(c) || c == 8'h5f) begin
               mode_in = cstl_pkg::MODE_WORD; begin_in = pos_ff;
               count_in = cstl_pkg::LEN_BITS'(1); prefix_in = {40'd0, c};
            end else if (cstl_pkg::is_digit(c)) begin
               mode_in = cstl_pkg::MODE_NUMBER; begin_in = pos_ff;
               count_in = cstl_pkg::LEN_BITS'(1);
            end else if (c == 8'h3d || c == 8'h21 || c == 8'h3c || c == 8'h3e) begin
               mode_in = cstl_pkg::MODE_CMP; held_in = c; begin_in = pos_ff;
            end else begin
               if (c == 8'h2b || c == 8'h2d || c == 8'h2a)
                  tk.kind = cstl_pkg::KIND_OPERATOR;
               else if (c == 8'h3b || c == 8'h2c || c == 8'h28 || c == 8'h29 ||
                        c == 8'h7b || c == 8'h7d)
                  tk.kind = cstl_pkg::KIND_DELIM;
               else
                  tk.kind = cstl_pkg::KIND_UNKNOWN;
               list[n] = tk; n = n + 1'b1;
            end
         end
         if (end_of_text) finish = 1'b1;
      end

      // Close the text: flush pending token, add end token, clear state
      if (finish) begin
         kw = cstl_pkg::keyword_lookup(prefix_in, count_in);
         tk = '0;
         tk.start = begin_in;
         tk.length = count_in;
         if (mode_in == cstl_pkg::MODE_WORD) begin
            tk.kind = kw[4] ? cstl_pkg::KIND_KEYWORD : cstl_pkg::KIND_IDENT;
            tk.keyword = kw[4] ? kw[3:0] : 4'd0;
            list[n] = tk; n = n + 1'b1;
         end else if (mode_in == cstl_pkg::MODE_NUMBER) begin
            tk.kind = cstl_pkg::KIND_NUMBER;
            list[n] = tk; n = n + 1'b1;
         end else if (mode_in == cstl_pkg::MODE_SLASH || mode_in == cstl_pkg::MODE_CMP) begin
            tk.kind = cstl_pkg::KIND_OPERATOR;
            tk.length = cstl_pkg::LEN_BITS'(1);
            tk.sym1 = (mode_in == cstl_pkg::MODE_SLASH) ? 8'h2f : held_in;
            list[n] = tk; n = n + 1'b1;
         end
         tk = '0;
         tk.kind = cstl_pkg::KIND_END;
         tk.start = endpos;
         list[n] = tk; n = n + 1'b1;
         mode_in = cstl_pkg::MODE_IDLE;
         pos_in = '0; begin_in = '0; count_in = '0; prefix_in = '0; held_in = '0;
      end

      // Mark the last token of the burst
      if (n != 2'd0) list[n - 1'b1].last = 1'b1;
      burst.count = n;
      burst.t0 = list[0];
      burst.t1 = list[1];
      burst.t2 = list[2];
   end

endmodule

@@ hw/rtl/cstl_queue.sv @@
// Token queue between front and back: takes a burst of up to three tokens
// per cycle, hands out one token per pop. Depends on cstl_pkg.
module cstl_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  cstl_pkg::burst_type  burst,
   output logic                 room,
   input  logic                 pop,
   output logic                 empty,
   output cstl_pkg::token_type  head
);

   cstl_pkg::token_type             mem_ff [cstl_pkg::QUEUE_SLOTS];
   logic [cstl_pkg::QPTR_BITS-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [cstl_pkg::FILL_BITS-1:0]  fill_ff, fill_in;
   logic [1:0]                      n_push;
   logic                            do_pop;

   assign n_push = push ? burst.count : 2'd0;
   assign do_pop = pop && fill_ff != '0;
   assign empty  = fill_ff == '0;
   assign room   = fill_ff <= cstl_pkg::FILL_BITS'(cstl_pkg::QUEUE_SLOTS - 3);
   assign head   = mem_ff[rd_ff];
   assign wr_in  = wr_ff + cstl_pkg::QPTR_BITS'(n_push);
   assign rd_in  = rd_ff + cstl_pkg::QPTR_BITS'(do_pop);
   assign fill_in = fill_ff + cstl_pkg::FILL_BITS'(n_push) - cstl_pkg::FILL_BITS'(do_pop);

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; fill_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; fill_ff <= fill_in;
      end
   end

   // Write the burst into consecutive slots
   always_ff @(posedge clock) begin
      if (n_push >= 2'd1) mem_ff[wr_ff] <= burst.t0;
      if (n_push >= 2'd2) mem_ff[wr_ff + cstl_pkg::QPTR_BITS'(1)] <= burst.t1;
      if (n_push == 2'd3) mem_ff[wr_ff + cstl_pkg::QPTR_BITS'(2)] <= burst.t2;
   end

endmodule

@@ hw/rtl/cstl_back.sv @@
// Back end: output register stage that presents one token at a time on the
// result ports. Depends on cstl_pkg.
module cstl_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  cstl_pkg::token_type  q_head,
   output logic                 q_pop,
   input  logic                 pop,
   output logic                 empty,
   output cstl_pkg::token_type  token
);

   logic                full_ff, full_in;
   cstl_pkg::token_type tok_ff;

   // Refill whenever the register is free or being drained
   assign q_pop   = !q_empty && (!full_ff || pop);
   assign full_in = q_pop || (full_ff && !pop);
   assign empty   = !full_ff;
   assign token   = tok_ff;

   always_ff @(posedge clock) begin
      if (reset) full_ff <= 1'b0;
      else       full_ff <= full_in;
   end

   always_ff @(posedge clock) begin
      if (q_pop) tok_ff <= q_head;
   end

endmodule

@@ hw/rtl/c_subset_token_lexer_unit.sv @@
// Top level of the streaming lexer for a subset of C.
// Instantiates cstl_front, cstl_queue and cstl_back; uses cstl_pkg.
//
// Usage: source bytes enter on req_text_byte/req_end_of_text, one request
// per cycle while full is low (push high, full low accepts). Tokens leave
// on the rsp_ ports while empty is low and are taken with pop.
// Each byte yields zero to three tokens; rsp_last_of_run marks the last.
// A token finished by a byte is written into the queue at the edge that
// accepts that byte, then into the output register once that is free or
// being taken; while the receiver stalls it waits in the queue.
// Throughput: one byte per cycle while full is low, set by the single mode
// machine step in the front end; the queue drains at most one token per cycle,
// so bursts of two or three tokens can fill it and raise full.
// Reset clears the scan state, offset and queue; no tokens are pending.
// When the receiver stalls, tokens wait in the queue and full rises once
// fewer than three free slots remain; nothing is lost.
module c_subset_token_lexer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_token_kind,
   output logic [31:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic [3:0]  rsp_keyword_number,
   output logic [7:0]  rsp_first_symbol,
   output logic [7:0]  rsp_second_symbol,
   output logic        rsp_last_of_run
);

   cstl_pkg::burst_type burst;
   cstl_pkg::token_type head, token;
   logic room, take, q_empty, q_pop;

   assign full = !room;
   assign take = push && room;

   cstl_front u_front (.clock, .reset, .take, .text_byte(req_text_byte),
                       .end_of_text(req_end_of_text), .burst);

   cstl_queue u_queue (.clock, .reset, .push(take), .burst, .room,
                       .pop(q_pop), .empty(q_empty), .head);

   cstl_back u_back (.clock, .reset, .q_empty, .q_head(head), .q_pop,
                     .pop, .empty, .token);

   assign rsp_token_kind     = token.kind;
   assign rsp_token_start    = token.start;
   assign rsp_token_length   = token.length;
   assign rsp_keyword_number = token.keyword;
   assign rsp_first_symbol   = token.sym1;
   assign rsp_second_symbol  = token.sym2;
   assign rsp_last_of_run    = token.last;

endmodule

@@ hw/rtl/cstl_checker.sv @@
// Port-level checks for the lexer, bound to the top level.
// Depends on cstl_pkg and the top level's ports.
module cstl_checker (
   input logic        clock,
   input logic        reset,
   input logic        push,
   input logic        full,
   input logic        empty,
   input logic        pop,
   input logic [2:0]  rsp_token_kind,
   input logic [15:0] rsp_token_length,
   input logic [7:0]  rsp_second_symbol,
   input logic        rsp_last_of_run
);

   // End token always closes a run and has no length
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_token_kind == cstl_pkg::KIND_END
         |-> rsp_last_of_run && rsp_token_length == 16'd0)
      else $error("end token malformed");

   // A pair operator is two bytes long
   a_pair_len: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_second_symbol != 8'd0 |-> rsp_token_length == 16'd2)
      else $error("pair operator length");

   // Nothing waits right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("not empty after reset");

   // A held result stays while not taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_token_kind))
      else $error("result dropped");

endmodule

bind c_subset_token_lexer_unit cstl_checker u_cstl_checker (.*);
